FILE: rtl/object_handle_allocator_core_macros.svh
// assertion macros for the object handle allocator
`ifndef OBJECT_HANDLE_ALLOCATOR_CORE_MACROS_SVH
`define OBJECT_HANDLE_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define OHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define OHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OHA_ASSERT_NOW(label, ante, cons, msg)
`define OHA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/oha_pkg.sv
// shared types and constants of the object handle allocator
`timescale 1ns / 1ps

package oha_pkg;

  localparam int ID_W    = 24;
  localparam int PROV_W  = 8;
  localparam int HANDLE_W = 32;
  localparam int POUID_W = 64;

  localparam logic [ID_W-1:0] MAX_OBJECT_ID = 24'hFF_FFFE;
  localparam logic [ID_W-1:0] MIN_OBJECT_ID = 24'h00_0000;
  localparam logic [POUID_W-1:0] POUID_START = '1;

  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_SEED       = 2'd1,
    OP_APPEND     = 2'd2,
    OP_NEXT_POUID = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_FULL      = 2'd2
  } status_e_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_POP  = 2'd2
  } state_t;

  // one free id block
  typedef struct packed {
    logic [ID_W-1:0] start;
    logic [ID_W-1:0] left;
  } blk_ent_t;

endpackage

FILE: rtl/oha_req_if.sv
// request channel of the object handle allocator
`timescale 1ns / 1ps

interface oha_req_if import oha_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic [PROV_W-1:0]          provider;
  logic [HANDLE_W-1:0]        handle_in;
  logic signed [POUID_W-1:0]  pouid_in;
  logic [ID_W-1:0]            block_length;

  modport source (
    output valid, operation, provider, handle_in, pouid_in, block_length,
    input  ready
  );
  modport sink (
    input  valid, operation, provider, handle_in, pouid_in, block_length,
    output ready
  );
endinterface

FILE: rtl/oha_rsp_if.sv
// response channel of the object handle allocator
`timescale 1ns / 1ps

interface oha_rsp_if import oha_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [HANDLE_W-1:0]        handle_out;
  logic signed [POUID_W-1:0]  pouid_out;
  logic [1:0]                 status;
  logic                       pool_has_room;

  modport source (
    output valid, handle_out, pouid_out, status, pool_has_room,
    input  ready
  );
  modport sink (
    input  valid, handle_out, pouid_out, status, pool_has_room,
    output ready
  );
endinterface

FILE: rtl/oha_prov_store.sv
// per-provider record memory with valid bits, unwritten entries read as zero
`timescale 1ns / 1ps

module oha_prov_store import oha_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 31,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

FILE: rtl/object_handle_allocator_core.sv
// object handle allocator: top level with provider table and free block pool
// usage:
//   req (sink) takes one word per operation: allocate, seed, append free
//   block, or next persistent id; rsp (source) returns exactly one word per
//   request, in order, with handle_out, pouid_out, status and pool_has_room.
// sequencing:
//   a word's result is formed in S_EXEC from the provider record read at
//   acceptance, then held in the output register; an allocate that draws
//   from the free block pool goes on through S_POP. req.ready is high only
//   in S_IDLE, while no request is in flight, so a word is not taken before
//   the last one is through. the provider table is a synchronous memory read
//   at acceptance and written at commit; a pool draw adds a read-modify-write
//   of the block memory entry at the provider's fifo head.
// reset:
//   synchronous, active high. per-provider counters, fifo head and fill
//   level read as zero through a valid bit per provider, cleared at once,
//   so there is no clearing pass. the persistent id counter starts at -1.
//   the block memory is not cleared: only live fifo entries are read.
// stalls:
//   the result sits in an output register; while rsp is stalled a new
//   request can still be taken, and its state commit waits until the
//   output register is free, so no word is lost or repeated.
`timescale 1ns / 1ps
`include "object_handle_allocator_core_macros.svh"

module object_handle_allocator_core import oha_pkg::*; #(
  parameter int NUM_PROVIDERS       = 256,
  parameter int BLOCKS_PER_PROVIDER = 8
) (
  input  logic       clk,
  input  logic       rst,
  oha_req_if.sink    req,
  oha_rsp_if.source  rsp
);

  // derived widths
  localparam int PW        = (NUM_PROVIDERS > 1) ? $clog2(NUM_PROVIDERS) : 1;
  localparam int HW        = (BLOCKS_PER_PROVIDER > 1) ? $clog2(BLOCKS_PER_PROVIDER) : 1;
  localparam int CW        = $clog2(BLOCKS_PER_PROVIDER + 1);
  localparam int TW        = CW + 1;
  localparam int BLK_DEPTH = NUM_PROVIDERS * BLOCKS_PER_PROVIDER;
  localparam int SW        = (BLK_DEPTH > 1) ? $clog2(BLK_DEPTH) : 1;

  // provider record: id counter, fifo head, fifo fill level
  typedef struct packed {
    logic [ID_W-1:0] last_id;
    logic [HW-1:0]   head;
    logic [CW-1:0]   count;
  } prov_rec_t;

  localparam int RW = $bits(prov_rec_t);

  // control state
  state_t st, st_next;
  logic   out_valid;
  logic   adv;
  logic   accept;

  // latched request
  op_e_t                     op_q;
  logic [PROV_W-1:0]         prov_q;
  logic                      bad_q;
  logic [HANDLE_W-1:0]       handle_q;
  logic signed [POUID_W-1:0] pouid_q;
  logic [ID_W-1:0]           blen_q;

  logic signed [POUID_W-1:0] last_pouid;

  // request decode at the input
  logic [PROV_W-1:0] rd_prov;
  logic              rd_bad;

  // provider table access
  prov_rec_t rec;
  logic [RW-1:0] rec_raw;
  logic      rec_we;
  prov_rec_t rec_wd;

  // block memory access
  blk_ent_t blk_mem [BLK_DEPTH];
  blk_ent_t blk_rd;
  logic     blk_re;
  logic     blk_we;
  logic [SW-1:0] blk_raddr;
  logic [SW-1:0] blk_waddr;
  blk_ent_t blk_wd;

  // datapath helpers
  logic [ID_W:0]  next_id;
  logic [HW-1:0]  head_inc;
  logic [TW-1:0]  tail_sum;
  logic [HW-1:0]  tail;
  logic [CW-1:0]  count_inc;
  logic [SW-1:0]  base_slot;
  logic [SW-1:0]  head_slot;
  logic [SW-1:0]  tail_slot;
  logic           pool_full;

  // result being formed
  logic                      res_load;
  logic [HANDLE_W-1:0]       res_handle;
  logic signed [POUID_W-1:0] res_pouid;
  status_e_t                 res_status;
  logic                      res_room;
  logic                      pouid_we;
  logic signed [POUID_W-1:0] pouid_next;

  assign adv       = !out_valid || rsp.ready;
  assign req.ready = (st == S_IDLE);
  assign accept    = req.valid && req.ready;

  // a seed addresses the provider named inside its handle
  assign rd_prov = (op_e_t'(req.operation) == OP_SEED) ? req.handle_in[31:24] : req.provider;
  assign rd_bad  = {1'b0, rd_prov} >= (PROV_W + 1)'(NUM_PROVIDERS);

  oha_prov_store #(
    .DEPTH (NUM_PROVIDERS),
    .WIDTH (RW),
    .AW    (PW)
  ) u_prov_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_prov[PW-1:0]),
    .rd_data (rec_raw),
    .wr_en   (rec_we),
    .wr_addr (prov_q[PW-1:0]),
    .wr_data (rec_wd)
  );

  assign rec = prov_rec_t'(rec_raw);

  // free block memory, entries undefined until appended
  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wd;
    end
    if (blk_re) begin
      blk_rd <= blk_mem[blk_raddr];
    end
  end

  // latch the request
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= op_e_t'(req.operation);
      prov_q   <= rd_prov;
      bad_q    <= rd_bad;
      handle_q <= req.handle_in;
      pouid_q  <= req.pouid_in;
      blen_q   <= req.block_length;
    end
  end

  // fifo slot arithmetic
  assign next_id   = {1'b0, rec.last_id} + (ID_W + 1)'(1);
  assign head_inc  = (rec.head == HW'(BLOCKS_PER_PROVIDER - 1)) ? '0 : rec.head + HW'(1);
  assign tail_sum  = TW'(rec.head) + TW'(rec.count);
  assign tail      = (tail_sum >= TW'(BLOCKS_PER_PROVIDER)) ?
                     HW'(tail_sum - TW'(BLOCKS_PER_PROVIDER)) : HW'(tail_sum);
  assign count_inc = rec.count + CW'(1);
  assign pool_full = rec.count >= CW'(BLOCKS_PER_PROVIDER);
  assign base_slot = SW'(prov_q[PW-1:0]) * SW'(BLOCKS_PER_PROVIDER);
  assign head_slot = base_slot + SW'(rec.head);
  assign tail_slot = base_slot + SW'(tail);

  // next state
  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: begin
        if (accept) begin
          st_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_q == OP_ALLOC && !bad_q && next_id > {1'b0, MAX_OBJECT_ID} &&
            rec.count != '0) begin
          st_next = S_POP;
        end else if (adv) begin
          st_next = S_IDLE;
        end
      end
      S_POP: begin
        if (adv) begin
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  // datapath control and results
  always_comb begin
    rec_we     = 1'b0;
    rec_wd     = rec;
    blk_re     = 1'b0;
    blk_raddr  = head_slot;
    blk_we     = 1'b0;
    blk_waddr  = tail_slot;
    blk_wd     = '{start: handle_q[ID_W-1:0], left: blen_q};
    res_load   = 1'b0;
    res_handle = '0;
    res_pouid  = '0;
    res_status = STAT_OK;
    res_room   = 1'b0;
    pouid_we   = 1'b0;
    pouid_next = last_pouid + POUID_W'(1);
    case (st)
      S_EXEC: begin
        case (op_q)
          OP_ALLOC: begin
            if (bad_q) begin
              res_status = STAT_EXHAUSTED;
              res_load   = adv;
            end else if (next_id <= {1'b0, MAX_OBJECT_ID}) begin
              rec_wd.last_id = next_id[ID_W-1:0];
              rec_we         = adv;
              res_handle     = {prov_q, next_id[ID_W-1:0]};
              res_load       = adv;
            end else if (rec.count == '0) begin
              res_status = STAT_EXHAUSTED;
              res_load   = adv;
            end else begin
              // counter spent: fetch the head block of the pool
              blk_re = 1'b1;
            end
          end
          OP_SEED: begin
            if (!bad_q && handle_q[ID_W-1:0] > rec.last_id) begin
              rec_wd.last_id = handle_q[ID_W-1:0];
              rec_we         = adv;
            end
            if (pouid_q > last_pouid) begin
              pouid_next = pouid_q;
              pouid_we   = adv;
            end
            res_load = adv;
          end
          OP_APPEND: begin
            if (bad_q || pool_full) begin
              res_status = STAT_FULL;
            end else begin
              blk_we       = adv;
              rec_wd.count = count_inc;
              rec_we       = adv;
              res_room     = count_inc < CW'(BLOCKS_PER_PROVIDER);
            end
            res_load = adv;
          end
          OP_NEXT_POUID: begin
            pouid_we  = adv;
            res_pouid = pouid_next;
            res_load  = adv;
          end
          default: begin
            res_load = adv;
          end
        endcase
      end
      S_POP: begin
        // the provider record still sits in the table read register
        if (blk_rd.left <= ID_W'(1)) begin
          rec_wd.head  = head_inc;
          rec_wd.count = rec.count - CW'(1);
          rec_we       = adv;
        end else begin
          blk_waddr = head_slot;
          blk_wd    = '{start: blk_rd.start + ID_W'(1), left: blk_rd.left - ID_W'(1)};
          blk_we    = adv;
        end
        if (blk_rd.start <= MAX_OBJECT_ID) begin
          res_handle = {prov_q, blk_rd.start};
        end else begin
          res_status = STAT_EXHAUSTED;
        end
        res_load = adv;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      out_valid  <= 1'b0;
      last_pouid <= POUID_START;
    end else begin
      st <= st_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (pouid_we) begin
        last_pouid <= pouid_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp.handle_out    <= res_handle;
      rsp.pouid_out     <= res_pouid;
      rsp.status        <= res_status;
      rsp.pool_has_room <= res_room;
    end
  end

  assign rsp.valid = out_valid;

  // checks
  `OHA_ASSERT_NOW(a_no_write_idle, st == S_IDLE, !rec_we && !blk_we, "table write while idle")
  `OHA_ASSERT_NOW(a_pop_is_alloc, st == S_POP, op_q == OP_ALLOC, "pool draw without allocate")
  `OHA_ASSERT_NOW(a_blk_rw_apart, blk_re, !blk_we && !res_load, "block read overlaps a commit")
  `OHA_ASSERT_NEXT(a_result_shown, res_load, rsp.valid && st == S_IDLE, "result not presented")

endmodule
